### rtl/adsr_envelope_generator_defines.svh
// Assertion macros for the envelope generator
`ifndef ADSR_ENVELOPE_GENERATOR_DEFINES_SVH
`define ADSR_ENVELOPE_GENERATOR_DEFINES_SVH
`ifndef SYNTHESIS
`define ADSR_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ADSR_ASSERT_RST(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ADSR_ASSERT(label, clk, rst, prop, msg)
`define ADSR_ASSERT_RST(label, clk, prop, msg)
`endif
`endif

### rtl/adsr_pkg.sv
package adsr_pkg;
   localparam int Voices = 16;
   localparam int VoiceW = 4;
   localparam int DivW = 44;
   localparam int DenW = 33;

   typedef enum logic [1:0] {
      OP_TICK = 2'd0, OP_NOTE_ON = 2'd1, OP_NOTE_OFF = 2'd2, OP_NONE = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE = 3'd0, ST_ATTACK = 3'd1, ST_DECAY = 3'd2,
      ST_SUSTAIN = 3'd3, ST_RELEASE = 3'd4
   } stage_type;

   typedef enum logic [2:0] {
      REG_ATTACK = 3'd0, REG_DECAY = 3'd1, REG_SUSTAIN = 3'd2,
      REG_RELEASE = 3'd3, REG_RATE = 3'd4
   } reg_type;

   typedef enum logic [2:0] {
      FSM_IDLE, FSM_READ, FSM_MUL, FSM_DIV, FSM_APPLY, FSM_OUT
   } fsm_type;
endpackage

### rtl/adsr_envelope_generator.sv
// Channel  Dir  tdata (low bit up)               tuser
// req_     in   op[1:0], voice[5:2]               -
// rsp_     out  voice_out[3:0], env_level[28:4]   -
// csr_     in   write enable, index, data         -
// Attack and decay ticks step through accept, read, multiply, divide (44-bit quotient,
// then done), apply and output load.
// Note-off on a live voice skips the output load, other ticks skip the divide; note-on,
// note-off on an idle voice and unused ops end after the multiply.
// Reset is synchronous; stages clear to idle, levels and steps to zero.
// req_tready is high only when the sequencer is idle; a tick waits in its output
// load while the previous word still waits on rsp_.
`include "adsr_envelope_generator_defines.svh"
module adsr_envelope_generator (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   input  logic [7:0] req_tdata,   // op, voice
   output logic rsp_tvalid,
   input  logic rsp_tready,
   output logic [31:0] rsp_tdata,  // voice_out, env_level
   input  logic csr_we,
   input  logic [2:0] csr_index,
   input  logic [17:0] csr_wdata
);
   import adsr_pkg::*;

   logic [14:0] atk_ff, dec_ff, rel_ff;
   logic [16:0] sus_ff;
   logic [17:0] rate_ff;

   stage_type stage_ff [Voices];
   stage_type stage_in;
   logic [32:0] level_ff [Voices];
   logic [32:0] level_in;
   logic [31:0] rinc_ff [Voices];
   logic [31:0] rinc_in;
   logic wr_en;

   fsm_type fsm_ff, fsm_in;
   op_type op_ff, op_in;
   logic [VoiceW-1:0] voice_ff, voice_in;
   stage_type cur_stage_ff, cur_stage_in;
   logic [32:0] cur_level_ff, cur_level_in;
   logic [31:0] cur_rinc_ff, cur_rinc_in;
   logic [32:0] span_ff, span_in;
   logic out_valid_ff, out_valid_in;
   logic [24:0] out_level_ff, out_level_in;
   logic [VoiceW-1:0] out_voice_ff, out_voice_in;

   logic div_start, div_busy, div_done;
   logic [32:0] num_base;
   logic [DivW-1:0] div_num;
   logic [DivW-1:0] quo;
   logic [32:0] sus_q32;
   logic [14:0] ms_sel;
   logic [32:0] step;
   logic [33:0] sum;

   adsr_divider u_div (
      .clock(clock), .reset(reset), .start(div_start), .dividend(div_num),
      .divisor(span_ff), .busy(div_busy), .done(div_done), .quotient(quo)
   );

   assign sus_q32 = (sus_ff > 17'd65536) ? {1'b1, 32'd0} : {sus_ff, 16'd0};
   assign req_tready = (fsm_ff == FSM_IDLE);
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata = {3'd0, out_level_ff, out_voice_ff};

   always_comb begin
      case (cur_stage_ff)
         ST_ATTACK: ms_sel = atk_ff;
         ST_DECAY: ms_sel = dec_ff;
         default: ms_sel = rel_ff;
      endcase
      if (op_ff == OP_NOTE_OFF) ms_sel = rel_ff;
      // clamp quotient to 33 bits, floor 1
      if (quo[DivW-1:33] != '0) step = {1'b1, 32'd0};
      else step = quo[32:0];
      if (step == '0) step = 33'd1;
      sum = {1'b0, cur_level_ff} + {1'b0, step};
   end

   always_comb begin
      fsm_in = fsm_ff;
      op_in = op_ff;
      voice_in = voice_ff;
      cur_stage_in = cur_stage_ff;
      cur_level_in = cur_level_ff;
      cur_rinc_in = cur_rinc_ff;
      span_in = span_ff;
      num_base = cur_level_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      out_level_in = out_level_ff;
      out_voice_in = out_voice_ff;
      div_start = 1'b0;
      wr_en = 1'b0;
      stage_in = cur_stage_ff;
      level_in = cur_level_ff;
      rinc_in = cur_rinc_ff;
      case (fsm_ff)
         FSM_IDLE: begin
            if (req_tvalid && req_tready) begin
               op_in = op_type'(req_tdata[1:0]);
               voice_in = req_tdata[5:2];
               fsm_in = FSM_READ;
            end
         end
         FSM_READ: begin
            cur_stage_in = stage_ff[voice_ff];
            cur_level_in = level_ff[voice_ff];
            cur_rinc_in = rinc_ff[voice_ff];
            fsm_in = FSM_MUL;
         end
         FSM_MUL: begin
            span_in = 33'((ms_sel == '0 ? 15'd1 : ms_sel)
                          * (rate_ff == '0 ? 18'd1 : rate_ff));
            case (op_ff)
               OP_NOTE_ON: begin
                  wr_en = 1'b1;
                  stage_in = ST_ATTACK;
                  fsm_in = FSM_IDLE;
               end
               OP_NOTE_OFF: begin
                  num_base = cur_level_ff;
                  if (cur_stage_ff == ST_IDLE) fsm_in = FSM_IDLE;
                  else fsm_in = FSM_DIV;
               end
               OP_TICK: begin
                  if (cur_stage_ff == ST_DECAY) num_base = {1'b1, 32'd0} - sus_q32;
                  else num_base = {1'b1, 32'd0};
                  if (cur_stage_ff == ST_ATTACK || cur_stage_ff == ST_DECAY)
                     fsm_in = FSM_DIV;
                  else fsm_in = FSM_APPLY;
               end
               default: fsm_in = FSM_IDLE;
            endcase
            if (fsm_in == FSM_DIV) div_start = 1'b1;
         end
         FSM_DIV: begin
            if (div_done) fsm_in = FSM_APPLY;
         end
         FSM_APPLY: begin
            wr_en = 1'b1;
            if (op_ff == OP_NOTE_OFF) begin
               stage_in = ST_RELEASE;
               rinc_in = step[32] ? 32'hFFFF_FFFF : step[31:0];
               fsm_in = FSM_IDLE;
            end else begin
               case (cur_stage_ff)
                  ST_ATTACK: begin
                     if (sum >= {1'b0, 1'b1, 32'd0}) begin
                        level_in = {1'b1, 32'd0};
                        stage_in = ST_DECAY;
                     end else level_in = sum[32:0];
                  end
                  ST_DECAY: begin
                     level_in = (step >= cur_level_ff) ? '0 : cur_level_ff - step;
                     if (level_in <= sus_q32) begin
                        level_in = sus_q32;
                        stage_in = ST_SUSTAIN;
                     end
                  end
                  ST_SUSTAIN: level_in = sus_q32;
                  ST_RELEASE: begin
                     if ({1'b0, cur_rinc_ff} >= cur_level_ff) begin
                        level_in = '0;
                        stage_in = ST_IDLE;
                     end else level_in = cur_level_ff - {1'b0, cur_rinc_ff};
                  end
                  default: level_in = cur_level_ff;
               endcase
               // new level held for the output load
               cur_level_in = level_in;
               fsm_in = FSM_OUT;
            end
         end
         FSM_OUT: begin
            if (!out_valid_ff || rsp_tready) begin
               out_valid_in = 1'b1;
               out_level_in = cur_level_ff[32:8];
               out_voice_in = voice_ff;
               fsm_in = FSM_IDLE;
            end
         end
         default: fsm_in = FSM_IDLE;
      endcase
      // times 1000 as 1024 - 16 - 8
      div_num = DivW'({num_base, 10'd0}) - DivW'({num_base, 4'd0})
                - DivW'({num_base, 3'd0});
   end

   always_ff @(posedge clock) begin
      op_ff <= op_in;
      voice_ff <= voice_in;
      cur_stage_ff <= cur_stage_in;
      cur_level_ff <= cur_level_in;
      cur_rinc_ff <= cur_rinc_in;
      span_ff <= span_in;
      out_level_ff <= out_level_in;
      out_voice_ff <= out_voice_in;
      if (reset) begin
         fsm_ff <= FSM_IDLE;
         out_valid_ff <= 1'b0;
         atk_ff <= 15'd10;
         dec_ff <= 15'd100;
         sus_ff <= 17'd45875;
         rel_ff <= 15'd300;
         rate_ff <= 18'd48000;
         for (int i = 0; i < Voices; i++) begin
            stage_ff[i] <= ST_IDLE;
            level_ff[i] <= '0;
            rinc_ff[i] <= '0;
         end
      end else begin
         fsm_ff <= fsm_in;
         out_valid_ff <= out_valid_in;
         if (wr_en) begin
            stage_ff[voice_ff] <= stage_in;
            level_ff[voice_ff] <= level_in;
            rinc_ff[voice_ff] <= rinc_in;
         end
         if (csr_we) begin
            case (reg_type'(csr_index))
               REG_ATTACK: atk_ff <= csr_wdata[14:0];
               REG_DECAY: dec_ff <= csr_wdata[14:0];
               REG_SUSTAIN: sus_ff <= csr_wdata[16:0];
               REG_RELEASE: rel_ff <= csr_wdata[14:0];
               REG_RATE: rate_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   `ADSR_ASSERT(a_div_only_in_div, clock, reset, div_busy |-> (fsm_ff == FSM_DIV), "divider busy")
   `ADSR_ASSERT(a_no_accept_busy, clock, reset, (fsm_ff != FSM_IDLE) |-> !req_tready, "ready busy")
   `ADSR_ASSERT(a_out_after_load, clock, reset, $rose(out_valid_ff) |-> $past(fsm_ff) == FSM_OUT, "stray")
   `ADSR_ASSERT_RST(a_reset_idle, clock, $past(reset) |-> (fsm_ff == FSM_IDLE && !out_valid_ff), "not idle")
endmodule

### rtl/adsr_divider.sv
module adsr_divider (
   input  logic clock,
   input  logic reset,
   input  logic start,
   input  logic [adsr_pkg::DivW-1:0] dividend,
   input  logic [adsr_pkg::DenW-1:0] divisor,
   output logic busy,
   output logic done,
   output logic [adsr_pkg::DivW-1:0] quotient
);
   import adsr_pkg::*;

   logic [DivW-1:0] quot_ff, quot_in;
   logic [DenW:0] rem_ff, rem_in;
   logic [5:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in, done_ff, done_in;
   logic [DenW:0] trial;

   // one quotient bit a cycle, restoring
   always_comb begin
      quot_in = quot_ff;
      rem_in = rem_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial = {rem_ff[DenW-1:0], quot_ff[DivW-1]};
      if (start) begin
         quot_in = dividend;
         rem_in = '0;
         cnt_in = 6'(DivW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, divisor}) begin
            rem_in = trial - {1'b0, divisor};
            quot_in = {quot_ff[DivW-2:0], 1'b1};
         end else begin
            rem_in = trial;
            quot_in = {quot_ff[DivW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quot_ff <= quot_in;
      rem_ff <= rem_in;
      if (reset) begin
         cnt_ff <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign busy = busy_ff;
   assign done = done_ff;
   assign quotient = quot_ff;
endmodule

### verif/tb_adsr_envelope_generator.sv
`timescale 1ns / 1ps

module tb_adsr_envelope_generator;
   import adsr_pkg::*;

   localparam int ClockHigh = 10;
   localparam int ClockLow = 10;
   localparam int ResetCycles = 6;
   localparam int SettleCycles = 80;     // long enough for a note-off still running in the divider
   localparam int IdleLimit = 20000;
   localparam int HoldOffCycles = 2500;
   localparam int RandomPhases = 8;
   localparam int WordsPerPhase = 250;
   localparam logic [2:0] RegUnused = 3'd5;
   localparam longint unsigned OneQ32 = 64'd4294967296;
   localparam longint unsigned MaxStep = 64'hFFFF_FFFF;

   typedef struct {
      op_type      op;
      logic [3:0]  voice;
      bit          typed;
      logic [24:0] level;
   } stim_row_type;

   typedef struct {
      logic [3:0]  voice;
      logic [24:0] level;
   } level_word_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;
   logic        csr_we;
   logic [2:0]  csr_index;
   logic [17:0] csr_wdata;

   // register shadow and per-voice envelope state
   logic [14:0] attack_time, decay_time, release_time;
   logic [16:0] sustain_reg;
   logic [17:0] rate_reg;
   stage_type   env_stage [Voices];
   logic [32:0] env_level [Voices];
   logic [31:0] fall_step [Voices];

   level_word_type pending_levels[$];
   int          mismatches = 0;
   int          words_sent = 0;
   int          levels_seen = 0;
   int          idle_cycles = 0;
   bit          no_idle = 0;
   bit          csr_busy = 0;

   adsr_envelope_generator u_top (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      clock = 1'b1;
      #ClockHigh;
      clock = 1'b0;
      #ClockLow;
   end

   function automatic longint unsigned span_of(input logic [14:0] ms);
      longint unsigned t, r;
      t = (ms == 0) ? 1 : ms;
      r = (rate_reg == 0) ? 1 : rate_reg;
      return t * r;
   endfunction

   function automatic void envelope_step(input op_type op, input logic [3:0] v,
                                         output bit emits, output logic [24:0] lvl_out);
      longint unsigned sus, stepv, lv;
      sus = ((sustain_reg > 65536) ? 64'd65536 : longint'(sustain_reg)) << 16;
      emits = 0;
      lvl_out = '0;
      case (op)
         OP_NOTE_ON: begin
            env_stage[v] = ST_ATTACK;
         end
         OP_NOTE_OFF: begin
            if (env_stage[v] != ST_IDLE) begin
               env_stage[v] = ST_RELEASE;
               stepv = (longint'(env_level[v]) * 1000) / span_of(release_time);
               if (stepv < 1) stepv = 1;
               if (stepv > MaxStep) stepv = MaxStep;
               fall_step[v] = stepv[31:0];
            end
         end
         OP_TICK: begin
            lv = env_level[v];
            case (env_stage[v])
               ST_ATTACK: begin
                  stepv = (OneQ32 * 1000) / span_of(attack_time);
                  if (stepv < 1) stepv = 1;
                  lv += stepv;
                  if (lv >= OneQ32) begin
                     lv = OneQ32;
                     env_stage[v] = ST_DECAY;
                  end
               end
               ST_DECAY: begin
                  stepv = ((OneQ32 - sus) * 1000) / span_of(decay_time);
                  if (stepv < 1) stepv = 1;
                  lv = (stepv >= lv) ? 0 : lv - stepv;
                  if (lv <= sus) begin
                     lv = sus;
                     env_stage[v] = ST_SUSTAIN;
                  end
               end
               ST_SUSTAIN: lv = sus;
               ST_RELEASE: begin
                  if (fall_step[v] >= lv) begin
                     lv = 0;
                     env_stage[v] = ST_IDLE;
                  end else begin
                     lv -= fall_step[v];
                  end
               end
               default: ;
            endcase
            env_level[v] = lv[32:0];
            emits = 1;
            lvl_out = env_level[v][32:8];
         end
         default: ;
      endcase
   endfunction

   task automatic send_word(input op_type op, input logic [3:0] v,
                            input bit typed, input logic [24:0] typed_level);
      bit          emits;
      logic [24:0] lvl;
      int          gap, r;
      req_tvalid <= 1'b1;
      req_tdata <= {2'b00, v, op};
      do @(posedge clock); while (!req_tready);
      words_sent++;
      envelope_step(op, v, emits, lvl);
      if (emits) pending_levels.push_back('{v, typed ? typed_level : lvl});
      r = $urandom_range(0, 99);
      gap = (no_idle || r < 55) ? 0 : (r < 95) ? $urandom_range(1, 4) : $urandom_range(20, 200);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic settle();
      req_tvalid <= 1'b0;
      while (pending_levels.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic write_regs(input logic [17:0] att, input logic [17:0] dec,
                             input logic [17:0] sus, input logic [17:0] rel,
                             input logic [17:0] rate);
      logic [17:0] vals [5];
      vals = '{att, dec, sus, rel, rate};
      csr_busy = 1;
      for (int i = 0; i < 5; i++) begin
         csr_we <= 1'b1;
         csr_index <= 3'(i);
         csr_wdata <= vals[i];
         @(posedge clock);
      end
      // index past the register file must be harmless
      csr_index <= RegUnused;
      csr_wdata <= 18'($urandom);
      @(posedge clock);
      csr_we <= 1'b0;
      csr_busy = 0;
      attack_time = att[14:0];
      decay_time = dec[14:0];
      sustain_reg = sus[16:0];
      release_time = rel[14:0];
      rate_reg = rate;
   endtask

   function automatic op_type pick_op();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return OP_TICK;
      if (r < 78) return OP_NOTE_ON;
      if (r < 95) return OP_NOTE_OFF;
      return OP_NONE;
   endfunction

   // result side: random back-pressure plus one long hold-off
   initial begin
      int stall_left, r;
      bit held;
      level_word_type want;
      stall_left = 0;
      held = 0;
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            levels_seen++;
            if (pending_levels.size() == 0) begin
               $display("%0t: unexpected word voice %0d level %0d", $time,
                        rsp_tdata[3:0], rsp_tdata[28:4]);
               mismatches++;
            end else begin
               want = pending_levels.pop_front();
               if (rsp_tdata[3:0] !== want.voice) begin
                  $display("%0t: voice expected %0d actual %0d", $time,
                           want.voice, rsp_tdata[3:0]);
                  mismatches++;
               end
               if (rsp_tdata[28:4] !== want.level) begin
                  $display("%0t: level expected %0d actual %0d (voice %0d)", $time,
                           want.level, rsp_tdata[28:4], want.voice);
                  mismatches++;
               end
            end
         end
         if (stall_left > 0) begin
            stall_left--;
         end else if (!held && levels_seen >= 400) begin
            held = 1;
            rsp_tready <= 1'b0;
            stall_left = HoldOffCycles;
         end else begin
            r = $urandom_range(0, 99);
            if (no_idle || r < 65) begin
               rsp_tready <= 1'b1;
            end else begin
               rsp_tready <= 1'b0;
               stall_left = (r < 96) ? $urandom_range(0, 3) : $urandom_range(10, 120);
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_busy || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles == IdleLimit) begin
         $display("%0t: watchdog expired, %0d words still expected", $time,
                  pending_levels.size());
         $display("end of test: mismatches");
         $finish;
      end
   end

   stim_row_type directed[] = '{
      '{OP_TICK,     4'd0,  1'b1, 25'd0},
      '{OP_NONE,     4'd0,  1'b0, 25'd0},
      '{OP_NOTE_OFF, 4'd1,  1'b0, 25'd0},   // idle voice, ignored
      '{OP_TICK,     4'd1,  1'b1, 25'd0},
      '{OP_NOTE_ON,  4'd2,  1'b0, 25'd0},
      '{OP_TICK,     4'd2,  1'b0, 25'd0},
      '{OP_TICK,     4'd2,  1'b0, 25'd0},
      '{OP_NOTE_ON,  4'd2,  1'b0, 25'd0},   // retrigger keeps level
      '{OP_TICK,     4'd2,  1'b0, 25'd0},
      '{OP_NOTE_OFF, 4'd2,  1'b0, 25'd0},
      '{OP_TICK,     4'd2,  1'b0, 25'd0},
      '{OP_NOTE_OFF, 4'd2,  1'b0, 25'd0},   // step recomputed mid release
      '{OP_TICK,     4'd2,  1'b0, 25'd0},
      '{OP_TICK,     4'd15, 1'b1, 25'd0},
      '{OP_NOTE_ON,  4'd15, 1'b0, 25'd0},
      '{OP_TICK,     4'd15, 1'b0, 25'd0},
      // zero times, zero rate, sustain above one
      '{OP_NOTE_ON,  4'd0,  1'b0, 25'd0},
      '{OP_TICK,     4'd0,  1'b1, 25'd16777216},
      '{OP_TICK,     4'd0,  1'b1, 25'd16777216},
      '{OP_NOTE_OFF, 4'd0,  1'b0, 25'd0},
      '{OP_TICK,     4'd0,  1'b1, 25'd0},
      '{OP_TICK,     4'd0,  1'b1, 25'd0},
      '{OP_TICK,     4'd0,  1'b1, 25'd0}
   };
   localparam int FastRow = 16;

   initial begin
      logic [3:0] v;
      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      csr_we <= 1'b0;
      csr_index <= '0;
      csr_wdata <= '0;
      attack_time = 15'd10;
      decay_time = 15'd100;
      sustain_reg = 17'd45875;
      release_time = 15'd300;
      rate_reg = 18'd48000;
      for (int i = 0; i < Voices; i++) begin
         env_stage[i] = ST_IDLE;
         env_level[i] = '0;
         fall_step[i] = '0;
      end
      repeat (ResetCycles) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[i]) begin
         if (i == FastRow) begin
            settle();
            write_regs(18'd0, 18'd0, 18'h1FFFF, 18'd0, 18'd0);
         end
         send_word(directed[i].op, directed[i].voice, directed[i].typed, directed[i].level);
      end

      for (int ph = 0; ph < RandomPhases; ph++) begin
         settle();
         no_idle = (ph == 2 || ph == 5);
         case (ph)
            0: write_regs(18'h7FFF, 18'h7FFF, 18'd65536, 18'h7FFF, 18'h3FFFF);
            1: write_regs(18'd1, 18'd1, 18'd0, 18'd1, 18'd8000);
            default: write_regs(18'($urandom_range(0, 8)), 18'($urandom_range(0, 12)),
                                18'($urandom_range(0, 70000)), 18'($urandom_range(0, 15)),
                                18'(($urandom_range(0, 3) == 0) ? $urandom_range(8000, 192000)
                                                                : $urandom_range(0, 3000)));
         endcase
         for (int n = 0; n < WordsPerPhase; n++) begin
            // mostly a few busy voices so envelopes run through all stages
            v = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15))
                                            : 4'($urandom_range(0, 3));
            send_word(pick_op(), v, 1'b0, '0);
         end
      end

      settle();
      $display("%0d words sent over %0d register settings, %0d levels checked",
               words_sent, RandomPhases + 2, levels_seen);
      if (mismatches == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end
endmodule
